>>> sv/hcs_pkg.sv
// Package for the 2-D hill-climb search unit: payload types, codes and constants.
`timescale 1ns / 1ps

package hcs_pkg;

    // Fixed field widths
    localparam int FIELD_W = 64;
    localparam int STEP_W  = 62;

    // Default parameter values
    localparam int DEF_FRAC_BITS   = 30;
    localparam int DEF_COORD_WIDTH = 64;

    // Initial step in whole units, scaled by the fraction bits at reset
    localparam longint unsigned STEP_START_UNITS = 64'd1000000;
    localparam logic [STEP_W-1:0] STEP_STOP_RST  = STEP_W'(1);

    // round(sqrt(3)/2 * 2^32)
    localparam logic [31:0] SQRT3_HALF_Q32 = 32'd3719550787;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_STOP  = 1'b1;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_VALUE = 1'b1;

    // Probe directions, 60 degrees apart, counterclockwise from +x
    localparam int DIR_W = 3;
    localparam logic [DIR_W-1:0] DIR_E    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NE   = 3'd1;
    localparam logic [DIR_W-1:0] DIR_NW   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_W_   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_SW   = 3'd4;
    localparam logic [DIR_W-1:0] DIR_SE   = 3'd5;
    localparam logic [DIR_W-1:0] NUM_DIRS = 3'd6;

    typedef enum logic [1:0] {
        ST_PROBE   = 2'd0,
        ST_DONE    = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_INIT  = 2'd1,
        PH_PROBE = 2'd2
    } phase_t;

    typedef struct packed {
        logic                      req_type;
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] objective_value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic signed [FIELD_W-1:0] min_value;
    } rsp_t;

endpackage

>>> sv/hcs_req_if.sv
// Request channel interface: valid/ready handshake with request payload.
`timescale 1ns / 1ps

interface hcs_req_if
    import hcs_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/hcs_rsp_if.sv
// Result channel interface: valid/ready handshake with result payload.
`timescale 1ns / 1ps

interface hcs_rsp_if
    import hcs_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/hcs_sat_add.sv
// Saturating add of a signed coordinate and a signed-magnitude step offset.
`timescale 1ns / 1ps

module hcs_sat_add
    import hcs_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic signed [COORD_WIDTH-1:0] coord,
    input  logic        [STEP_W-1:0]      mag,
    input  logic                          neg,
    output logic signed [COORD_WIDTH-1:0] sum
);
    // Two guard bits over the wider of the operands
    localparam int SW = ((COORD_WIDTH > STEP_W) ? COORD_WIDTH : STEP_W) + 2;
    localparam logic signed [SW-1:0] ONE  = 1;
    localparam logic signed [SW-1:0] MAXV = (ONE <<< (COORD_WIDTH - 1)) - ONE;
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    logic signed [SW-1:0] coord_ext;
    logic signed [SW-1:0] mag_ext;
    logic signed [SW-1:0] raw;

    assign coord_ext = SW'(coord);
    assign mag_ext   = SW'(mag);
    assign raw       = neg ? (coord_ext - mag_ext) : (coord_ext + mag_ext);

    // Clamp to the coordinate range
    always_comb
    begin
        priority if (raw > MAXV)
        begin
            sum = MAXV[COORD_WIDTH-1:0];
        end
        else if (raw < MINV)
        begin
            sum = MINV[COORD_WIDTH-1:0];
        end
        else
        begin
            sum = raw[COORD_WIDTH-1:0];
        end
    end
endmodule

>>> sv/hcs_step_scale.sv
// Registered step * sqrt(3)/2 (Q32 constant) for the diagonal probe offsets.
`timescale 1ns / 1ps

module hcs_step_scale
    import hcs_pkg::*;
(
    input  logic              clk,
    input  logic [STEP_W-1:0] step_next,
    output logic [STEP_W-1:0] step_r
);
    logic [STEP_W-33:0] hi;
    logic [31:0]        lo;
    logic [STEP_W-1:0]  prod_hi;
    logic [63:0]        prod_lo;
    logic [STEP_W-1:0]  r_next;
    logic [STEP_W-1:0]  r_reg;

    // Split product: high part times K plus the top of low part times K
    assign hi      = step_next[STEP_W-1:32];
    assign lo      = step_next[31:0];
    assign prod_hi = STEP_W'(hi) * STEP_W'(SQRT3_HALF_Q32);
    assign prod_lo = 64'(lo) * 64'(SQRT3_HALF_Q32);
    assign r_next  = prod_hi + STEP_W'(prod_lo[63:32]);

    // Tracks the step register one for one
    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign step_r = r_reg;
endmodule

>>> sv/hcs_core.sv
// Search state and per-transaction update: probe sequencing, round check, result.
`timescale 1ns / 1ps

module hcs_core
    import hcs_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  req_t              item,
    input  logic [STEP_W-1:0] step_start,
    input  logic [STEP_W-1:0] step_stop,
    output rsp_t              result
);
    localparam logic signed [FIELD_W-1:0] ONE64 = 1;
    localparam logic signed [FIELD_W-1:0] CMAX  = (ONE64 <<< (COORD_WIDTH - 1)) - ONE64;
    localparam logic signed [FIELD_W-1:0] CMIN  = ~CMAX;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // State registers
    phase_t             phase_reg, phase_next;
    logic               improved_reg, improved_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    coord_t             pos_x_reg, pos_x_next;
    coord_t             pos_y_reg, pos_y_next;
    coord_t             probe_x_reg, probe_x_next;
    coord_t             probe_y_reg, probe_y_next;
    coord_t             best_x_reg, best_x_next;
    coord_t             best_y_reg, best_y_next;
    logic signed [FIELD_W-1:0] cur_val_reg, cur_val_next;
    logic signed [FIELD_W-1:0] best_val_reg, best_val_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [STEP_W-1:0]  step_r;

    // Working signals
    logic                      is_start;
    coord_t                    start_x_c, start_y_c;
    logic signed [FIELD_W-1:0] val;
    logic                      better;
    logic signed [FIELD_W-1:0] best_val_upd;
    coord_t                    best_x_upd, best_y_upd;
    logic                      impr_upd;
    logic [DIR_W-1:0]          dir_inc;
    logic                      round_end;
    logic                      do_round;
    coord_t                    rnd_pos_x, rnd_pos_y;
    logic signed [FIELD_W-1:0] rnd_cur;
    logic [STEP_W-1:0]         rnd_step;
    logic                      go_on;
    coord_t                    rnd_probe_x;
    logic [STEP_W-1:0]         off_x, off_y;
    logic                      neg_x, neg_y;
    coord_t                    np_x, np_y;

    assign is_start = (item.req_type == REQ_START);
    assign val      = item.objective_value;

    // Start point clamped to the coordinate range
    always_comb
    begin
        priority if (item.start_x > CMAX)
        begin
            start_x_c = CMAX[COORD_WIDTH-1:0];
        end
        else if (item.start_x < CMIN)
        begin
            start_x_c = CMIN[COORD_WIDTH-1:0];
        end
        else
        begin
            start_x_c = item.start_x[COORD_WIDTH-1:0];
        end
        priority if (item.start_y > CMAX)
        begin
            start_y_c = CMAX[COORD_WIDTH-1:0];
        end
        else if (item.start_y < CMIN)
        begin
            start_y_c = CMIN[COORD_WIDTH-1:0];
        end
        else
        begin
            start_y_c = item.start_y[COORD_WIDTH-1:0];
        end
    end

    // Round best update from the value of the last probe (strictly smaller wins)
    assign better       = (best_val_reg > val);
    assign best_val_upd = better ? val : best_val_reg;
    assign best_x_upd   = better ? probe_x_reg : best_x_reg;
    assign best_y_upd   = better ? probe_y_reg : best_y_reg;
    assign impr_upd     = improved_reg | better;
    assign dir_inc      = dir_reg + DIR_W'(1);
    assign round_end    = (dir_inc >= NUM_DIRS);
    assign do_round     = !is_start &&
                          ((phase_reg == PH_INIT) || ((phase_reg == PH_PROBE) && round_end));

    // Inputs to the round check: after the initial value, or after the sixth probe
    always_comb
    begin
        if (phase_reg == PH_INIT)
        begin
            rnd_pos_x = pos_x_reg;
            rnd_pos_y = pos_y_reg;
            rnd_cur   = val;
            rnd_step  = step_reg;
        end
        else
        begin
            rnd_pos_x = impr_upd ? best_x_upd : pos_x_reg;
            rnd_pos_y = impr_upd ? best_y_upd : pos_y_reg;
            rnd_cur   = impr_upd ? best_val_upd : cur_val_reg;
            rnd_step  = impr_upd ? step_reg : {1'b0, step_reg[STEP_W-1:1]};
        end
    end

    assign go_on = (rnd_step > step_stop);

    // First probe of a new round lies along +x
    hcs_sat_add #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_round_x (
        .coord (rnd_pos_x),
        .mag   (rnd_step),
        .neg   (1'b0),
        .sum   (rnd_probe_x)
    );

    // Offsets of the next probe within the round
    always_comb
    begin
        unique case (dir_inc)
            DIR_NE:
            begin
                off_x = {1'b0, step_reg[STEP_W-1:1]};
                off_y = step_r;
                neg_x = 1'b0;
                neg_y = 1'b0;
            end
            DIR_NW:
            begin
                off_x = {1'b0, step_reg[STEP_W-1:1]};
                off_y = step_r;
                neg_x = 1'b1;
                neg_y = 1'b0;
            end
            DIR_W_:
            begin
                off_x = step_reg;
                off_y = '0;
                neg_x = 1'b1;
                neg_y = 1'b0;
            end
            DIR_SW:
            begin
                off_x = {1'b0, step_reg[STEP_W-1:1]};
                off_y = step_r;
                neg_x = 1'b1;
                neg_y = 1'b1;
            end
            DIR_SE:
            begin
                off_x = {1'b0, step_reg[STEP_W-1:1]};
                off_y = step_r;
                neg_x = 1'b0;
                neg_y = 1'b1;
            end
            default:
            begin
                off_x = step_reg;
                off_y = '0;
                neg_x = 1'b0;
                neg_y = 1'b0;
            end
        endcase
    end

    hcs_sat_add #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_probe_x (
        .coord (pos_x_reg),
        .mag   (off_x),
        .neg   (neg_x),
        .sum   (np_x)
    );

    hcs_sat_add #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_probe_y (
        .coord (pos_y_reg),
        .mag   (off_y),
        .neg   (neg_y),
        .sum   (np_y)
    );

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        improved_next = improved_reg;
        dir_next      = dir_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        probe_x_next  = probe_x_reg;
        probe_y_next  = probe_y_reg;
        best_x_next   = best_x_reg;
        best_y_next   = best_y_reg;
        best_val_next = best_val_reg;
        cur_val_next  = cur_val_reg;
        step_next     = step_reg;
        if (fire)
        begin
            if (is_start)
            begin
                pos_x_next    = start_x_c;
                pos_y_next    = start_y_c;
                step_next     = step_start;
                improved_next = 1'b0;
                dir_next      = DIR_E;
                phase_next    = PH_INIT;
            end
            else if (phase_reg == PH_PROBE)
            begin
                best_val_next = best_val_upd;
                best_x_next   = best_x_upd;
                best_y_next   = best_y_upd;
                improved_next = impr_upd;
                dir_next      = dir_inc;
                probe_x_next  = np_x;
                probe_y_next  = np_y;
            end
            if (do_round)
            begin
                pos_x_next   = rnd_pos_x;
                pos_y_next   = rnd_pos_y;
                cur_val_next = rnd_cur;
                step_next    = rnd_step;
                if (go_on)
                begin
                    best_val_next = rnd_cur;
                    best_x_next   = rnd_pos_x;
                    best_y_next   = rnd_pos_y;
                    improved_next = 1'b0;
                    dir_next      = DIR_E;
                    probe_x_next  = rnd_probe_x;
                    probe_y_next  = rnd_pos_y;
                    phase_next    = PH_PROBE;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    // Result of the current transaction
    always_comb
    begin
        result.status    = ST_IGNORED;
        result.point_x   = '0;
        result.point_y   = '0;
        result.min_value = '0;
        if (is_start)
        begin
            result.status  = ST_PROBE;
            result.point_x = FIELD_W'(start_x_c);
            result.point_y = FIELD_W'(start_y_c);
        end
        else if (do_round)
        begin
            if (go_on)
            begin
                result.status  = ST_PROBE;
                result.point_x = FIELD_W'(rnd_probe_x);
                result.point_y = FIELD_W'(rnd_pos_y);
            end
            else
            begin
                result.status    = ST_DONE;
                result.point_x   = FIELD_W'(rnd_pos_x);
                result.point_y   = FIELD_W'(rnd_pos_y);
                result.min_value = rnd_cur;
            end
        end
        else if (phase_reg == PH_PROBE)
        begin
            result.status  = ST_PROBE;
            result.point_x = FIELD_W'(np_x);
            result.point_y = FIELD_W'(np_y);
        end
    end

    // Diagonal offset magnitude follows the step register
    hcs_step_scale u_scale (
        .clk       (clk),
        .step_next (step_next),
        .step_r    (step_r)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            improved_reg <= 1'b0;
            dir_reg      <= DIR_E;
        end
        else
        begin
            phase_reg    <= phase_next;
            improved_reg <= improved_next;
            dir_reg      <= dir_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        probe_x_reg  <= probe_x_next;
        probe_y_reg  <= probe_y_next;
        best_x_reg   <= best_x_next;
        best_y_reg   <= best_y_next;
        best_val_reg <= best_val_next;
        cur_val_reg  <= cur_val_next;
        step_reg     <= step_next;
    end
endmodule

>>> sv/hill_climb_search_2d_unit.sv
// Path: a request is registered in the input stage; the core result is registered in the
//   output stage, which drives rsp.valid; a full output stage with rsp.ready low holds it back.
// Throughput: one transaction per cycle unless rsp.ready stalls; the clock is set by
//   the compare of the probe value, the best-point select and the saturating add.
// The step * sqrt(3)/2 product is registered alongside the step itself.
// Reset (rst_n, async, active low): search idle, both stages empty, step_start
//   = 1e6 in fixed point, step_stop = 1.
`timescale 1ns / 1ps

module hill_climb_search_2d_unit
    import hcs_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    hcs_req_if.sink              req,
    hcs_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [STEP_W-1:0]    cfg_wdata
);
    localparam logic [STEP_W-1:0] STEP_START_RST = STEP_W'(STEP_START_UNITS << FRAC_BITS);

    logic [STEP_W-1:0] step_start_reg;
    logic [STEP_W-1:0] step_stop_reg;
    logic              in_valid_reg;
    req_t              in_data_reg;
    logic              out_valid_reg;
    rsp_t              out_data_reg;
    logic              take;
    rsp_t              result;

    // Core consumes the input stage when the output stage is free or draining
    assign take      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || take;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_start_reg <= STEP_START_RST;
            step_stop_reg  <= STEP_STOP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_STEP_START: step_start_reg <= cfg_wdata;
                CFG_STEP_STOP:  step_stop_reg  <= cfg_wdata;
                default:        step_stop_reg  <= step_stop_reg;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
    end

    hcs_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (take),
        .item       (in_data_reg),
        .step_start (step_start_reg),
        .step_stop  (step_stop_reg),
        .result     (result)
    );

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= result;
        end
    end
endmodule
